@@ rtl/core/b2da_pkg.sv @@
// shared types and constants for the binary16 to decimal ascii converter
package b2da_pkg;

   localparam int unsigned ValueWidth = 16;
   localparam int unsigned DigitCount = 5;
   localparam int unsigned PlaceWidth = 3;
   localparam logic [PlaceWidth-1:0] UnitsPlace = PlaceWidth'(DigitCount - 1);
   localparam logic [1:0] AsciiZeroHigh = 2'b11;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic sub;
      logic advance;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic ge;
      logic digit_nz;
      logic started;
      logic at_units;
   } status_type;

   function automatic logic [ValueWidth-1:0] place_weight(input logic [1:0] idx);
      logic [ValueWidth-1:0] w;
      unique case (idx)
         2'd0: w = 16'h2710;
         2'd1: w = 16'h03e8;
         2'd2: w = 16'h0064;
         2'd3: w = 16'h000a;
         default: w = 16'h000a;
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/b2da_ctrl.sv @@
// sequencer for the digit extraction and emission
module b2da_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  b2da_pkg::status_type status,
   output b2da_pkg::cmd_type    cmd
);
   import b2da_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            busy = 1'b1;
            priority if (status.at_units) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end else if (status.ge) begin
               cmd.sub = 1'b1;
            end else begin
               // digit finished: show it once a non-zero digit has been seen
               cmd.advance = 1'b1;
               cmd.emit    = status.digit_nz | status.started;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/b2da_datapath.sv @@
// remainder, digit counter and result registers
module b2da_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         req_value_high,
   input  logic [7:0]         req_value_low,
   input  b2da_pkg::cmd_type    cmd,
   output b2da_pkg::status_type status,
   output logic               rsp_strobe,
   output logic [5:0]         rsp_digit_char,
   output logic               rsp_last_digit
);
   import b2da_pkg::*;

   logic [ValueWidth-1:0] rem_ff;
   logic [ValueWidth-1:0] rem_in;
   logic [3:0]            digit_ff;
   logic [3:0]            digit_in;
   logic [PlaceWidth-1:0] place_ff;
   logic [PlaceWidth-1:0] place_in;
   logic                  started_ff;
   logic                  started_in;
   logic                  strobe_ff;
   logic                  strobe_in;
   logic [5:0]            char_ff;
   logic [5:0]            char_in;
   logic                  last_ff;
   logic                  last_in;
   logic [ValueWidth-1:0] weight;
   logic [3:0]            out_digit;

   assign weight = place_weight(place_ff[1:0]);

   assign status.ge       = rem_ff >= weight;
   assign status.digit_nz = digit_ff != 4'd0;
   assign status.started  = started_ff;
   assign status.at_units = place_ff == UnitsPlace;

   // at the units place the remainder itself is the digit
   assign out_digit = status.at_units ? rem_ff[3:0] : digit_ff;

   always_comb begin
      rem_in     = rem_ff;
      digit_in   = digit_ff;
      place_in   = place_ff;
      started_in = started_ff;
      strobe_in  = cmd.emit;
      char_in    = char_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         rem_in     = {req_value_high, req_value_low};
         digit_in   = 4'd0;
         place_in   = '0;
         started_in = 1'b0;
      end
      if (cmd.sub) begin
         rem_in   = rem_ff - weight;
         digit_in = digit_ff + 4'd1;
      end
      if (cmd.advance) begin
         place_in   = place_ff + PlaceWidth'(1);
         digit_in   = 4'd0;
         started_in = started_ff | status.digit_nz;
      end
      if (cmd.emit) begin
         char_in = {AsciiZeroHigh, out_digit};
         last_in = status.at_units;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      digit_ff   <= digit_in;
      place_ff   <= place_in;
      started_ff <= started_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

@@ rtl/core/binary16_to_decimal_ascii.sv @@
// top level: 16-bit binary to ascii decimal, leading zeros suppressed
// the value is loaded, then each upper decimal place is found by repeated subtraction of its
// weight and an advance step, and the units digit is taken from the remainder
// throughput: one transaction at a time, busy covers the subtract loop of the datapath
// results are registered and leave in the cycle after each digit is settled, one per cycle at most
// reset clears the sequencer and the result strobe; the receiver cannot stall
module binary16_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_value_high,
   input  logic [7:0] req_value_low,
   output logic       rsp_strobe,
   output logic [5:0] rsp_digit_char,
   output logic       rsp_last_digit
);
   import b2da_pkg::*;

   cmd_type    cmd;
   status_type status;

   b2da_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   b2da_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value_high (req_value_high),
      .req_value_low  (req_value_low),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

`ifndef SYNTHESIS
   a_strobe_from_run: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a running transaction");

   a_start_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not start");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_digit) |-> !busy)
      else $error("still busy after the units digit");

   a_char_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_digit_char[5:4] == 2'b11 && rsp_digit_char[3:0] <= 4'd9))
      else $error("result is not a decimal digit character");
`endif

endmodule

@@ bench/tb_binary16_to_decimal_ascii.sv @@
// self-checking bench for the 16-bit binary to ascii decimal converter
module tb_binary16_to_decimal_ascii;
   import b2da_pkg::*;

   localparam int ClockPeriod = 20;
   localparam int ResetCycles = 7;
   localparam int RandomValues = 220;
   localparam int IdlePercent = 22;
   localparam int CalmFirst = 90;
   localparam int CalmLast = 150;
   localparam int DrainCycles = 60;
   localparam int StallLimit = 3000;

   typedef struct {
      logic [7:0] high;
      logic [7:0] low;
   } value_item_type;

   typedef struct {
      logic [5:0] digit_char;
      logic       last_digit;
   } digit_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [7:0] req_value_high = 8'h00;
   logic [7:0] req_value_low = 8'h00;
   logic       rsp_strobe;
   logic [5:0] rsp_digit_char;
   logic       rsp_last_digit;

   value_item_type   value_items_q[$];
   digit_result_type decimal_chars_q[$];

   int reset_cycles = 0;
   int values_taken = 0;
   int chars_checked = 0;
   int error_count = 0;
   int stall_cycles = 0;
   int width_seen[DigitCount+1];

   // zero, every digit width at its edges, interior zeros and alternating bits
   int directed_values[] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 65535, 65534,
                             65530, 16'hff00, 16'h00ff, 16'h8000, 16'h5555, 16'haaaa,
                             10001, 20000, 60000, 59999, 40506, 1010, 100};

   binary16_to_decimal_ascii DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value_high (req_value_high),
      .req_value_low  (req_value_low),
      .rsp_strobe     (rsp_strobe),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // splits the value into decimal places and queues the characters it should produce
   task automatic predict_decimal_chars(input logic [7:0] hi, input logic [7:0] lo);
      int               weights[DigitCount];
      logic [3:0]       digits[DigitCount];
      int               remainder;
      int               lead;
      digit_result_type ch;
      weights = '{10000, 1000, 100, 10, 1};
      remainder = {hi, lo};
      for (int k = 0; k < DigitCount; k++) begin
         digits[k] = 4'(remainder / weights[k]);
         remainder = remainder % weights[k];
      end
      lead = DigitCount - 1;
      for (int k = DigitCount - 2; k >= 0; k--) begin
         if (digits[k] != 4'd0) lead = k;
      end
      for (int k = lead; k < DigitCount; k++) begin
         ch.digit_char = {2'b11, digits[k]};
         ch.last_digit = (k == DigitCount - 1);
         decimal_chars_q.push_back(ch);
      end
      width_seen[DigitCount - lead]++;
   endtask

   task automatic queue_value(input int v);
      value_item_type item;
      item.high = v[15:8];
      item.low = v[7:0];
      value_items_q.push_back(item);
   endtask

   // driver: request held until taken, random gaps only between transactions
   always @(posedge clock) begin : drive
      logic taken;
      logic idle_now;
      if (reset_cycles != ResetCycles) begin
         reset_cycles <= reset_cycles + 1;
         if (reset_cycles == ResetCycles - 1) reset <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            predict_decimal_chars(req_value_high, req_value_low);
            void'(value_items_q.pop_front());
            values_taken++;
         end
         idle_now = ($urandom_range(99) < IdlePercent);
         if (values_taken >= CalmFirst && values_taken < CalmLast) idle_now = 1'b0;
         if (start && !taken) begin
            start <= 1'b1;
         end else if (!idle_now && value_items_q.size() != 0) begin
            start <= 1'b1;
            req_value_high <= value_items_q[0].high;
            req_value_low <= value_items_q[0].low;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin : watch
      digit_result_type exp_ch;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if ((start && !busy) || rsp_strobe) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (rsp_strobe) begin
            chars_checked++;
            if (decimal_chars_q.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                         rsp_digit_char, rsp_last_digit));
            end else begin
               exp_ch = decimal_chars_q.pop_front();
               if (rsp_digit_char !== exp_ch.digit_char)
                  report_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                            rsp_digit_char, exp_ch.digit_char));
               if (rsp_last_digit !== exp_ch.last_digit)
                  report_mismatch($sformatf("last_digit %0b, expected %0b",
                                            rsp_last_digit, exp_ch.last_digit));
            end
         end
      end
   end

   initial begin
      int v;
      foreach (width_seen[i]) width_seen[i] = 0;
      foreach (directed_values[i]) begin
         queue_value(directed_values[i]);
      end
      for (int i = 0; i < RandomValues; i++) begin
         case ($urandom_range(5))
            0: v = $urandom_range(9);
            1: v = $urandom_range(99, 10);
            2: v = $urandom_range(999, 100);
            3: v = $urandom_range(9999, 1000);
            4: v = $urandom_range(65535, 10000);
            default: v = $urandom() & 16'hffff;
         endcase
         queue_value(v);
      end
      do @(posedge clock);
      while (reset || start || value_items_q.size() != 0 || decimal_chars_q.size() != 0);
      repeat (DrainCycles) @(posedge clock);
      if (decimal_chars_q.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", decimal_chars_q.size()));
      $display("converted %0d values into %0d characters", values_taken, chars_checked);
      $display("values by digit count 1..5: %0d %0d %0d %0d %0d",
               width_seen[1], width_seen[2], width_seen[3], width_seen[4], width_seen[5]);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      wait (stall_cycles >= StallLimit);
      $display("timeout: no transaction for %0d cycles", StallLimit);
      $display("FAILURE");
      $finish;
   end

endmodule
